/* design/deq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // Capacity and derived widths
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);

  // Field widths of the items
  localparam int unsigned OP_W   = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            capture;      // latch op and value of the accepted item
    logic            wr_back;      // write value behind the back, grow
    logic            wr_front;     // move front down, write value there, grow
    logic            rd_front;     // read front slot, advance front, shrink
    logic            rd_back;      // read back slot, shrink
    logic            srch_first;   // start a scan at the front
    logic            srch_next;    // scan the next position
    logic            res_load;     // load the result registers
    logic [ST_W-1:0] res_status;
    logic            res_data_rd;  // result data from the read port, else zero
    logic            res_pos_hit;  // result position from the scan index, else zero
    logic            out_load;     // move the result into the output stage
  } dq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            match;
    logic            last;
    logic            out_free;
  } dq_stat_t;

  // Reduce a sum of two slot indexes (each below DEPTH) modulo DEPTH
  function automatic logic [AW-1:0] dq_wrap(input logic [AW:0] sum);
    logic [AW:0] red;
    red = (sum >= (AW+1)'(DEPTH)) ? (sum - (AW+1)'(DEPTH)) : sum;
    return red[AW-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/double_ended_queue_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of up to DEPTH (16) signed 32-bit values with push and pop
// at both ends and a search for the first entry equal to a given value. Each
// input item carries an op and a value and yields exactly one result item with
// the popped data, a status (ok, empty, full, not found), the search position
// counted from the front and the occupancy after the op. Items are handled one
// at a time, and each holds the input off from its accepting cycle until the
// input can accept again. A push or an unknown op goes through accept, execute
// and respond; a pop adds a read of the slot through the registered port of the
// entry memory; a search adds a scan that reads one slot per cycle from that
// single read port and covers the entries up to the hit, or all of them on a
// miss. The result is loaded into the output register as the controller
// returns to accepting. It sits there while it waits, so the next item is
// accepted while the previous result waits to be taken. A further result
// that finds the output register still occupied holds the input off until
// the output register is free. Entries need no clearing after reset.
module double_ended_queue_core
  import deq_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Input items
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [2:0] op, [34:3] value, [39:35] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result items
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [31:0] data_out, [33:32] status, [37:34] position, [42:38] occupancy,
  // [47:43] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  dq_cmd_t          cmd;
  dq_stat_t         stat;
  logic [VAL_W-1:0] out_data;
  logic [ST_W-1:0]  out_status;
  logic [POS_W-1:0] out_pos;
  logic [OCC_W-1:0] out_occ;

  // Sequence each item: capture, execute, optional read or scan, respond
  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold entries, front pointer, count, scan index and result registers
  deq_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (s_axis_tdata[OP_W-1:0]),
    .in_value_i   (s_axis_tdata[OP_W+VAL_W-1:OP_W]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (out_data),
    .out_status_o (out_status),
    .out_pos_o    (out_pos),
    .out_occ_o    (out_occ)
  );

  // Pack the result item, pad with zeros to whole bytes
  assign m_axis_tdata = {(OUT_TDATA_W - VAL_W - ST_W - POS_W - OCC_W)'(0),
                         out_occ, out_pos, out_status, out_data};

`ifndef SYNTH
  // Never write a slot while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_back || cmd.wr_front) |-> !stat.full)
    else $error("push executed on a full queue");

  // Never pop while the queue is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_front || cmd.rd_back) |-> !stat.empty)
    else $error("pop executed on an empty queue");

  // A reported occupancy never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[42:38] <= OCC_W'(DEPTH)))
    else $error("occupancy above capacity");

  // An empty status comes only with an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[33:32] == ST_EMPTY)) |-> (m_axis_tdata[42:38] == '0))
    else $error("empty status with nonzero occupancy");

  // Loading the output stage only when it is free keeps results from being lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

/* design/deq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dq_stat_t stat_i,
  output dq_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RDWT = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_OK;
        state_d          = S_RESP;
        case (stat_i.op)
          OP_PUSH_BACK: begin
            if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.wr_back = 1'b1;
            end
          end
          OP_PUSH_FRONT: begin
            if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.wr_front = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (stat_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.res_load = 1'b0;
              cmd_o.rd_front = 1'b1;
              state_d        = S_RDWT;
            end
          end
          OP_POP_BACK: begin
            if (stat_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.res_load = 1'b0;
              cmd_o.rd_back  = 1'b1;
              state_d        = S_RDWT;
            end
          end
          OP_SEARCH: begin
            if (stat_i.empty) begin
              cmd_o.res_status = ST_NOT_FOUND;
            end else begin
              cmd_o.res_load   = 1'b0;
              cmd_o.srch_first = 1'b1;
              state_d          = S_SRCH;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDWT: begin
        cmd_o.res_load    = 1'b1;
        cmd_o.res_status  = ST_OK;
        cmd_o.res_data_rd = 1'b1;
        state_d           = S_RESP;
      end
      S_SRCH: begin
        if (stat_i.match) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_status  = ST_OK;
          cmd_o.res_pos_hit = 1'b1;
          state_d           = S_RESP;
        end else if (stat_i.last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_RESP;
        end else begin
          cmd_o.srch_next = 1'b1;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/deq_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module deq_dpath
  import deq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [OP_W-1:0]  in_op_i,
  input  wire logic [VAL_W-1:0] in_value_i,
  input  wire dq_cmd_t          cmd_i,
  output dq_stat_t              stat_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic [VAL_W-1:0]      out_data_o,
  output logic [ST_W-1:0]       out_status_o,
  output logic [POS_W-1:0]      out_pos_o,
  output logic [OCC_W-1:0]      out_occ_o
);

  logic [VAL_W-1:0] mem [DEPTH];

  logic [OP_W-1:0]  op_q;
  logic [VAL_W-1:0] val_q;
  logic [AW-1:0]    front_q, front_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    idx_q;
  logic [VAL_W-1:0] rd_data_q;
  logic [VAL_W-1:0] res_data_q;
  logic [ST_W-1:0]  res_status_q;
  logic [POS_W-1:0] res_pos_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_data_q;
  logic [ST_W-1:0]  out_status_q;
  logic [POS_W-1:0] out_pos_q;
  logic [OCC_W-1:0] out_occ_q;

  logic [AW-1:0]    front_dec, front_inc, slot_back, slot_last, slot_scan;
  logic [CW-1:0]    count_m1, idx_p1;
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;

  assign count_m1  = count_q - 1'b1;
  assign idx_p1    = CW'(idx_q) + 1'b1;
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : (front_q - 1'b1);
  assign front_inc = dq_wrap({1'b0, front_q} + (AW+1)'(1));
  assign slot_back = dq_wrap({1'b0, front_q} + {1'b0, count_q[AW-1:0]});
  assign slot_last = dq_wrap({1'b0, front_q} + {1'b0, count_m1[AW-1:0]});
  assign slot_scan = dq_wrap({1'b0, front_q} + {1'b0, idx_p1[AW-1:0]});

  assign wr_en   = cmd_i.wr_back | cmd_i.wr_front;
  assign wr_addr = cmd_i.wr_front ? front_dec : slot_back;
  assign rd_en   = cmd_i.rd_front | cmd_i.rd_back | cmd_i.srch_first | cmd_i.srch_next;

  always_comb begin
    rd_addr = front_q;
    if (cmd_i.rd_back) begin
      rd_addr = slot_last;
    end else if (cmd_i.srch_next) begin
      rd_addr = slot_scan;
    end
  end

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.wr_back) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.wr_front) begin
      front_d = front_dec;
      count_d = count_q + 1'b1;
    end else if (cmd_i.rd_front) begin
      front_d = front_inc;
      count_d = count_m1;
    end else if (cmd_i.rd_back) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_op_i;
      val_q <= in_value_i;
    end
    if (cmd_i.srch_first) begin
      idx_q <= '0;
    end else if (cmd_i.srch_next) begin
      idx_q <= idx_p1[AW-1:0];
    end
    if (cmd_i.res_load) begin
      res_data_q   <= cmd_i.res_data_rd ? rd_data_q : '0;
      res_status_q <= cmd_i.res_status;
      res_pos_q    <= cmd_i.res_pos_hit ? POS_W'(idx_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.match    = (rd_data_q == val_q);
  assign stat_o.last     = (idx_p1 == count_q);
  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;
  assign out_pos_o    = out_pos_q;
  assign out_occ_o    = out_occ_q;

endmodule

`default_nettype wire

/* dv/double_ended_queue_core_tb.sv */
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
  import deq_pkg::*;

  localparam int RAND_ITEMS   = 700;
  localparam int HOLD_AT      = 150;     // accepted items before the long sink stall
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_EVERY  = 200;     // random items between waits for every owed result to come back
  localparam int TAIL_CYCLES  = 40;      // longest op is a full-depth search
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [VAL_W-1:0] TAIL_MARK = 32'h5A5A_5A5A;

  // One deque operation as offered on the input stream
  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    bit                      drain;  // hold off until every result is back
  } deq_op_t;

  // One result item, fields as packed in m_axis_tdata
  typedef struct packed {
    logic signed [VAL_W-1:0] data;
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        position;
    logic [OCC_W-1:0]        occupancy;
  } deq_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  deq_op_t     op_q[$];       // operations still to be offered
  deq_result_t result_q[$];   // results owed by the block, oldest first
  deq_op_t     offer;         // operation currently on the input bus
  int          in_cnt = 0;
  int          quiet_from = 32'h7FFF_FFFF;
  int          fault_cnt = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          cycle_cnt = 0;
  logic        quiet;

  // Shadow deque: ring of slots, front slot index and entry count
  logic signed [VAL_W-1:0] ring[DEPTH];
  logic [AW-1:0]           head = '0;
  logic [CW-1:0]           fill = '0;

  // No idling on either side once the run nears its end
  assign quiet = (in_cnt >= quiet_from);

  double_ended_queue_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Physical slot of the entry at logical position pos from the front
  function automatic logic [AW-1:0] ring_slot(input int unsigned pos);
    return AW'((int'(head) + pos) % DEPTH);
  endfunction

  // Apply one operation to the shadow deque and return the result it owes
  function automatic deq_result_t apply_deq_op(input logic [OP_W-1:0] op,
                                               input logic signed [VAL_W-1:0] value);
    deq_result_t res;
    bit          hit;
    res = '0;
    hit = 1'b0;
    case (op)
      OP_PUSH_BACK: begin
        if (fill == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ring[ring_slot(fill)] = value;
          fill++;
        end
      end
      OP_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          head = AW'((int'(head) + DEPTH - 1) % DEPTH);
          ring[head] = value;
          fill++;
        end
      end
      OP_POP_FRONT: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = ring[head];
          head = AW'((int'(head) + 1) % DEPTH);
          fill--;
        end
      end
      OP_POP_BACK: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = ring[ring_slot(fill - 1)];
          fill--;
        end
      end
      OP_SEARCH: begin
        // First match from the front wins
        for (int unsigned k = 0; k < fill && !hit; k++) begin
          if (ring[ring_slot(k)] == value) begin
            hit = 1'b1;
            res.position = POS_W'(k);
          end
        end
        if (!hit) res.status = ST_NOT_FOUND;
      end
      default: ;  // unknown op: leave the deque alone
    endcase
    res.occupancy = OCC_W'(fill);
    return res;
  endfunction

  task automatic log_fault(input string msg);
    if (fault_cnt < 10) $display("%0t: %s", $time, msg);
    fault_cnt++;
  endtask

  task automatic add_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                        input bit drain = 1'b0);
    deq_op_t item;
    item.op    = op;
    item.value = value;
    item.drain = drain;
    op_q.push_back(item);
  endtask

  // Driver: offer operations, predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_left      <= 0;
      in_cnt        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(apply_deq_op(offer.op, offer.value));
        in_cnt <= in_cnt + 1;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the item until the block takes it
      end else if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (op_q.size() == 0 || (op_q[0].drain && result_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        gap_left      <= $urandom_range(1, 7) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        offer = op_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - VAL_W - OP_W){1'b0}}, offer.value, offer.op};
      end
    end
  end

  // Sink ready: one long stall so the block backs up, short random stalls otherwise
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && in_cnt >= HOLD_AT) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(1, 7) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: check each result item against the oldest prediction
  always @(posedge clk_i) begin
    deq_result_t got;
    deq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data      = m_axis_tdata[VAL_W-1:0];
      got.status    = m_axis_tdata[VAL_W +: ST_W];
      got.position  = m_axis_tdata[VAL_W + ST_W +: POS_W];
      got.occupancy = m_axis_tdata[VAL_W + ST_W + POS_W +: OCC_W];
      if (result_q.size() == 0) begin
        log_fault($sformatf("result with nothing expected: data %0d status %0d pos %0d occ %0d",
                            got.data, got.status, got.position, got.occupancy));
      end else begin
        want = result_q.pop_front();
        if (got.data !== want.data || got.status !== want.status ||
            got.position !== want.position || got.occupancy !== want.occupancy) begin
          log_fault($sformatf({"result mismatch: expected data %0d status %0d pos %0d ",
                               "occ %0d, got data %0d status %0d pos %0d occ %0d"},
                              want.data, want.status, want.position, want.occupancy,
                              got.data, got.status, got.position, got.occupancy));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [VAL_W-1:0] pool[8];
    logic [OP_W-1:0]  op;
    int               push_pct;
    int               r;

    // Empty-queue corner cases and an unknown op
    add_op(OP_POP_FRONT, '0);
    add_op(OP_POP_BACK, '0);
    add_op(OP_SEARCH, '0);
    add_op(OP_W'(OP_SEARCH + 1), 32'hFFFF_FFFF);
    // Extremes at both ends, then fill to capacity with the marker at the back
    add_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
    add_op(OP_PUSH_FRONT, 32'h8000_0000);
    for (int k = 0; k < DEPTH - 2; k++) begin
      add_op((k % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
             (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF :
             (k == DEPTH - 4) ? TAIL_MARK : $urandom());
    end
    // Refused pushes on a full queue, search hit at the last position, a miss
    add_op(OP_PUSH_BACK, 32'h1234_5678);
    add_op(OP_PUSH_FRONT, 32'h8765_4321);
    add_op(OP_SEARCH, TAIL_MARK);
    add_op(OP_SEARCH, $urandom());
    add_op(OP_W'((1 << OP_W) - 1), $urandom());
    add_op(OP_POP_BACK, $urandom());
    add_op(OP_POP_FRONT, $urandom());

    // Small value pool so searches hit often and duplicates test first-match
    pool[0] = 32'h0;
    pool[1] = 32'hFFFF_FFFF;
    pool[2] = 32'h7FFF_FFFF;
    pool[3] = 32'h8000_0000;
    for (int k = 4; k < 8; k++) pool[k] = $urandom();

    // Random phases alternate push-heavy, pop-heavy and balanced traffic
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case ((n / 40) % 3)
        0:       push_pct = 75;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = OP_W'($urandom_range(OP_SEARCH + 1, (1 << OP_W) - 1));
      end else if (r < 23) begin
        op = OP_SEARCH;
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      add_op(op, ($urandom_range(0, 99) < 60) ? pool[$urandom_range(0, 7)] : $urandom(),
             (n % DRAIN_EVERY) == 0);
    end
    quiet_from = op_q.size() * 9 / 10;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every operation to be taken and every result to come back
    @(negedge clk_i);
    while (op_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (result_q.size() != 0) begin
      log_fault($sformatf("%0d results never arrived", result_q.size()));
    end

    if (fault_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dpath.sv
design/double_ended_queue_core.sv
dv/double_ended_queue_core_tb.sv
